// ===== rtl/core/i2c_snoop_bit_patcher_macros.svh =====
// Assertion helpers shared by the snoop patcher RTL.
// Each macro expects clk and rst_n in scope.
`ifndef I2C_SNOOP_BIT_PATCHER_MACROS_SVH
`define I2C_SNOOP_BIT_PATCHER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define I2CSBP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define I2CSBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/i2csbp_pkg.sv =====
package i2csbp_pkg;

    // Default pattern lengths
    localparam int MATCH_BITS_DEF    = 19;
    localparam int OVERRIDE_BITS_DEF = 5;

    // Lockout counter width
    localparam int LOCKOUT_W = 22;

    // Register reset values (trimmed to the pattern length where used)
    localparam logic [31:0]          MATCH_RESET    = 32'd287104;
    localparam logic [7:0]           OVERRIDE_RESET = 8'd30;
    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET  = 22'd2880000;

    // Configuration register indexes
    localparam int          CFG_IDX_W    = 2;
    localparam logic [1:0]  REG_MATCH    = 2'd0;
    localparam logic [1:0]  REG_OVERRIDE = 2'd1;
    localparam logic [1:0]  REG_LOCKOUT  = 2'd2;

    // Snoop sequencer phases
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_MATCH = 2'd1,
        PH_ARM   = 2'd2,
        PH_DRIVE = 2'd3
    } phase_t;

    // One pin sample
    typedef struct packed {
        logic scl_in;
        logic sda_in;
        logic button_n;
    } i2csbp_in_t;

    // One result
    typedef struct packed {
        logic sda_drive_enable;
        logic sda_drive_level;
        logic enabled;
        logic patch_done;
    } i2csbp_out_t;

endpackage

// ===== rtl/core/i2csbp_core.sv =====
`include "i2c_snoop_bit_patcher_macros.svh"

module i2csbp_core
    import i2csbp_pkg::*;
#(
    parameter int MATCH_BITS    = MATCH_BITS_DEF,
    parameter int OVERRIDE_BITS = OVERRIDE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  i2csbp_in_t               item,
    input  logic [MATCH_BITS-1:0]    match_pattern,
    input  logic [OVERRIDE_BITS-1:0] override_pattern,
    input  logic [LOCKOUT_W-1:0]     lockout_ticks,
    output i2csbp_out_t              result
);

    localparam int CNT_MAX = (MATCH_BITS > OVERRIDE_BITS) ? MATCH_BITS : OVERRIDE_BITS;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int MATCH_IDX_W = (MATCH_BITS > 1) ? $clog2(MATCH_BITS) : 1;
    localparam int OVR_IDX_W   = (OVERRIDE_BITS > 1) ? $clog2(OVERRIDE_BITS) : 1;

    logic                     en_reg, en_next;
    logic                     prev_scl_reg, prev_sda_reg;
    phase_t                   phase_reg, phase_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [LOCKOUT_W-1:0]     lockout_reg, lockout_next;
    logic                     drive_on_reg, drive_on_next;
    logic                     drive_lvl_reg, drive_lvl_next;
    logic [MATCH_IDX_W-1:0]   match_idx;
    logic [OVR_IDX_W-1:0]     ovr_idx;
    logic                     done_next;

    logic rise, fall, start, match_last, match_bad, ovr_end, ovr_check, rb_bad;

    // Decode bus events from the previous and current samples
    always_comb
    begin
        rise       = !prev_scl_reg && item.scl_in;
        fall       = prev_scl_reg && !item.scl_in;
        start      = en_next && prev_sda_reg && !item.sda_in && item.scl_in;
        match_idx  = MATCH_IDX_W'(CNT_W'(MATCH_BITS - 1) - cnt_reg);
        ovr_idx    = OVR_IDX_W'(CNT_W'(OVERRIDE_BITS - 1) - cnt_reg);
        match_last = (cnt_reg == CNT_W'(MATCH_BITS - 1));
        match_bad  = (item.sda_in != match_pattern[match_idx]);
        ovr_end    = (cnt_reg >= CNT_W'(OVERRIDE_BITS));
        ovr_check  = (cnt_reg < CNT_W'(OVERRIDE_BITS - 1));
        rb_bad     = (item.sda_in != drive_lvl_reg);
    end

    // Button lockout: count down, else toggle snoop mode on a press while idle
    always_comb
    begin
        en_next      = en_reg;
        lockout_next = lockout_reg;
        if (lockout_reg != '0)
        begin
            lockout_next = lockout_reg - 1'b1;
        end
        else if (phase_reg == PH_IDLE && !item.button_n)
        begin
            en_next      = !en_reg;
            lockout_next = lockout_ticks;
        end
    end

    // Phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                    phase_next = PH_MATCH;
            end
            PH_MATCH:
            begin
                if (rise && match_bad)
                    phase_next = PH_IDLE;
                else if (rise && match_last)
                    phase_next = PH_ARM;
            end
            PH_ARM:
            begin
                if (fall)
                    phase_next = ovr_end ? PH_IDLE : PH_DRIVE;
            end
            PH_DRIVE:
            begin
                if (rise)
                    phase_next = (ovr_check && rb_bad) ? PH_IDLE : PH_ARM;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Bit counter and SDA drive
    always_comb
    begin
        cnt_next       = cnt_reg;
        drive_on_next  = drive_on_reg;
        drive_lvl_next = drive_lvl_reg;
        done_next      = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    cnt_next = '0;
                end
            end
            PH_MATCH:
            begin
                if (rise)
                begin
                    if (match_bad || match_last)
                    begin
                        cnt_next = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            PH_ARM:
            begin
                if (fall)
                begin
                    if (ovr_end)
                    begin
                        drive_on_next  = 1'b0;
                        drive_lvl_next = 1'b0;
                        cnt_next       = '0;
                        done_next      = 1'b1;
                    end
                    else
                    begin
                        drive_on_next  = 1'b1;
                        drive_lvl_next = override_pattern[ovr_idx];
                    end
                end
            end
            PH_DRIVE:
            begin
                if (rise)
                begin
                    // Release at once when the read-back of any driven bit but the last disagrees
                    if (ovr_check && rb_bad)
                    begin
                        drive_on_next  = 1'b0;
                        drive_lvl_next = 1'b0;
                        cnt_next       = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                drive_on_next = 1'b0;
            end
        endcase
    end

    // Result for this sample, taken from the updated state
    always_comb
    begin
        result.sda_drive_enable = drive_on_next;
        result.sda_drive_level  = drive_on_next & drive_lvl_next;
        result.enabled          = en_next;
        result.patch_done       = done_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg        <= 1'b0;
            prev_scl_reg  <= 1'b1;
            prev_sda_reg  <= 1'b1;
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            lockout_reg   <= '0;
            drive_on_reg  <= 1'b0;
            drive_lvl_reg <= 1'b0;
        end
        else if (step)
        begin
            en_reg        <= en_next;
            prev_scl_reg  <= item.scl_in;
            prev_sda_reg  <= item.sda_in;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            lockout_reg   <= lockout_next;
            drive_on_reg  <= drive_on_next;
            drive_lvl_reg <= drive_lvl_next;
        end
    end

    `I2CSBP_ASSERT_NOW(a_drive_only_when_patching, drive_on_reg,
        (phase_reg == PH_ARM || phase_reg == PH_DRIVE), "SDA driven outside override")
    `I2CSBP_ASSERT_NOW(a_match_count_range, phase_reg == PH_MATCH,
        cnt_reg <= CNT_W'(MATCH_BITS - 1), "match bit count out of range")
    `I2CSBP_ASSERT_NEXT(a_lockout_holds_mode, lockout_reg != '0,
        $stable(en_reg), "snoop mode changed during button lockout")

endmodule

// ===== rtl/core/i2c_snoop_bit_patcher.sv =====
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | in_data   : scl_in, sda_in, button_n
// out     | output    | out_valid/out_ready | out_data  : drive enable/level, enabled, done
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Each sample is processed combinationally and its result appears in the output
// register on the following cycle; one sample per cycle is sustained while out_ready is high.
// The output register is the only buffer: a new sample is taken while the
// held result is being taken, and input stalls only while out_ready is low.
// Reset leaves snoop mode off, SDA released and patterns at their defaults.
// Configuration writes are always taken; unknown indexes are ignored.
`include "i2c_snoop_bit_patcher_macros.svh"

module i2c_snoop_bit_patcher
    import i2csbp_pkg::*;
#(
    parameter int MATCH_BITS    = MATCH_BITS_DEF,
    parameter int OVERRIDE_BITS = OVERRIDE_BITS_DEF,
    localparam int CFG_W        = (MATCH_BITS > LOCKOUT_W) ? MATCH_BITS : LOCKOUT_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  i2csbp_in_t           in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output i2csbp_out_t          out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [MATCH_BITS-1:0]    match_reg, match_next;
    logic [OVERRIDE_BITS-1:0] override_reg, override_next;
    logic [LOCKOUT_W-1:0]     lockout_reg, lockout_next;
    logic                     out_valid_reg, out_valid_next;
    i2csbp_out_t              out_data_reg;
    i2csbp_out_t              result;
    logic                     step;
    logic                     cfg_we;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign step      = in_valid && in_ready;

    // Configuration register decode
    always_comb
    begin
        match_next    = match_reg;
        override_next = override_reg;
        lockout_next  = lockout_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MATCH:    match_next    = cfg_data[MATCH_BITS-1:0];
                REG_OVERRIDE: override_next = cfg_data[OVERRIDE_BITS-1:0];
                REG_LOCKOUT:  lockout_next  = cfg_data[LOCKOUT_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg    <= MATCH_RESET[MATCH_BITS-1:0];
            override_reg <= OVERRIDE_RESET[OVERRIDE_BITS-1:0];
            lockout_reg  <= LOCKOUT_RESET;
        end
        else
        begin
            match_reg    <= match_next;
            override_reg <= override_next;
            lockout_reg  <= lockout_next;
        end
    end

    // Snoop sequencer
    i2csbp_core #(
        .MATCH_BITS    (MATCH_BITS),
        .OVERRIDE_BITS (OVERRIDE_BITS)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .item             (in_data),
        .match_pattern    (match_reg),
        .override_pattern (override_reg),
        .lockout_ticks    (lockout_reg),
        .result           (result)
    );

    // Output register: load on each accepted transaction, hold while stalled
    assign out_valid_next = step || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `I2CSBP_ASSERT_NOW(a_done_releases, out_valid_reg && out_data_reg.patch_done,
        !out_data_reg.sda_drive_enable, "patch_done with SDA still driven")
    `I2CSBP_ASSERT_NOW(a_level_needs_enable, out_valid_reg && out_data_reg.sda_drive_level,
        out_data_reg.sda_drive_enable, "drive level set while SDA released")
    `I2CSBP_ASSERT_NEXT(a_accept_gives_result, step,
        out_valid_reg, "accepted transaction produced no result")

endmodule

// ===== tb/tb_i2c_snoop_bit_patcher.sv =====
`timescale 1ns / 100ps

module tb_i2c_snoop_bit_patcher;
    import i2csbp_pkg::*;

    localparam int CFG_W = (MATCH_BITS_DEF > LOCKOUT_W) ? MATCH_BITS_DEF : LOCKOUT_W;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 120;
    localparam int DIRECTED_LEN = 18;
    // Directed pin samples, {scl, sda, button_n}, first sample leftmost
    localparam logic [3*DIRECTED_LEN-1:0] DIRECTED_PINS = {
        3'b111, 3'b100, 3'b011, 3'b111, 3'b101, 3'b011,
        3'b111, 3'b110, 3'b110, 3'b110, 3'b110, 3'b111,
        3'b011, 3'b101, 3'b001, 3'b101, 3'b000, 3'b010
    };

    // Tracks the expected pin outputs for every accepted sample
    class patch_tracker;
        logic [MATCH_BITS_DEF-1:0]    match_pat;
        logic [OVERRIDE_BITS_DEF-1:0] ovr_pat;
        logic [LOCKOUT_W-1:0]         lock_ticks;
        logic [LOCKOUT_W-1:0]         lock_cnt;
        logic                         snoop_on;
        logic                         last_scl;
        logic                         last_sda;
        logic                         driving;
        logic                         drive_lvl;
        phase_t                       ph;
        int                           bit_idx;
        i2csbp_out_t                  patch_out_q[$];
        int                           errors;

        function new();
            match_pat  = MATCH_RESET[MATCH_BITS_DEF-1:0];
            ovr_pat    = OVERRIDE_RESET[OVERRIDE_BITS_DEF-1:0];
            lock_ticks = LOCKOUT_RESET;
            lock_cnt   = '0;
            snoop_on   = 1'b0;
            last_scl   = 1'b1;
            last_sda   = 1'b1;
            driving    = 1'b0;
            drive_lvl  = 1'b0;
            ph         = PH_IDLE;
            bit_idx    = 0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_MATCH:    match_pat  = val[MATCH_BITS_DEF-1:0];
                REG_OVERRIDE: ovr_pat    = val[OVERRIDE_BITS_DEF-1:0];
                REG_LOCKOUT:  lock_ticks = val[LOCKOUT_W-1:0];
                default:      ;
            endcase
        endfunction

        function int pending();
            return patch_out_q.size();
        endfunction

        // Advance the snoop sequencer by one pin sample and queue its outputs
        function void take_sample(i2csbp_in_t s);
            logic        rise;
            logic        fall;
            logic        done;
            i2csbp_out_t want;
            rise = !last_scl && s.scl_in;
            fall = last_scl && !s.scl_in;
            done = 1'b0;

            // Button lockout, mode toggles only in idle
            if (lock_cnt != 0)
                lock_cnt = lock_cnt - 1'b1;
            else if (ph == PH_IDLE && !s.button_n)
            begin
                snoop_on = !snoop_on;
                lock_cnt = lock_ticks;
            end

            case (ph)
                PH_IDLE:
                begin
                    if (snoop_on && last_sda && !s.sda_in && s.scl_in)
                    begin
                        ph      = PH_MATCH;
                        bit_idx = 0;
                    end
                end
                PH_MATCH:
                begin
                    if (rise)
                    begin
                        if (s.sda_in != match_pat[MATCH_BITS_DEF-1-bit_idx])
                        begin
                            ph      = PH_IDLE;
                            bit_idx = 0;
                        end
                        else if (bit_idx + 1 >= MATCH_BITS_DEF)
                        begin
                            ph      = PH_ARM;
                            bit_idx = 0;
                        end
                        else
                            bit_idx++;
                    end
                end
                PH_ARM:
                begin
                    if (fall)
                    begin
                        if (bit_idx >= OVERRIDE_BITS_DEF)
                        begin
                            driving   = 1'b0;
                            drive_lvl = 1'b0;
                            ph        = PH_IDLE;
                            bit_idx   = 0;
                            done      = 1'b1;
                        end
                        else
                        begin
                            driving   = 1'b1;
                            drive_lvl = ovr_pat[OVERRIDE_BITS_DEF-1-bit_idx];
                            ph        = PH_DRIVE;
                        end
                    end
                end
                default:
                begin
                    // Read-back check on every driven bit but the last
                    if (rise)
                    begin
                        if (bit_idx + 1 < OVERRIDE_BITS_DEF && s.sda_in != drive_lvl)
                        begin
                            driving   = 1'b0;
                            drive_lvl = 1'b0;
                            ph        = PH_IDLE;
                            bit_idx   = 0;
                        end
                        else
                        begin
                            bit_idx++;
                            ph = PH_ARM;
                        end
                    end
                end
            endcase

            last_scl = s.scl_in;
            last_sda = s.sda_in;

            want.sda_drive_enable = driving;
            want.sda_drive_level  = driving & drive_lvl;
            want.enabled          = snoop_on;
            want.patch_done       = done;
            patch_out_q.push_back(want);
        endfunction

        function void compare_field(string name, logic want, logic got);
            if (got !== want)
            begin
                $error("%s: expected %0b, got %0b", name, want, got);
                errors++;
            end
        endfunction

        // Compare one output transaction with the oldest expectation
        function void check_pins(i2csbp_out_t got);
            i2csbp_out_t want;
            if (patch_out_q.size() == 0)
            begin
                $error("output transaction %b with nothing expected", got);
                errors++;
                return;
            end
            want = patch_out_q.pop_front();
            compare_field("sda_drive_enable", want.sda_drive_enable, got.sda_drive_enable);
            compare_field("sda_drive_level", want.sda_drive_level, got.sda_drive_level);
            compare_field("enabled", want.enabled, got.enabled);
            compare_field("patch_done", want.patch_done, got.patch_done);
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    i2csbp_in_t           in_data   = '1;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    i2csbp_out_t          out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    patch_tracker board = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int sent_cnt      = 0;
    int cycle_cnt     = 0;
    bit stall_req     = 1'b0;

    i2c_snoop_bit_patcher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Output side: check each transaction, stall at random or on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                board.check_pins(out_data);
            if (stall_req)
            begin
                stall_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one pin sample and hold it until the block takes it
    task automatic send_sample(input logic scl, input logic sda, input logic btn);
        i2csbp_in_t s;
        s.scl_in   = scl;
        s.sda_in   = sda;
        s.button_n = btn;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.take_sample(s);
        sent_cnt++;
    endtask

    // Hold bus levels for one or two samples, with a rare stray button press
    task automatic hold_pins(input logic scl, input logic sda);
        repeat ($urandom_range(1, 2))
            send_sample(scl, sda, $urandom_range(39) != 0);
    endtask

    // Drop valid and wait until every expected transaction has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val,
                             input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_reg(idx, val);
        if (last)
            cfg_valid <= 1'b0;
    endtask

    // Press the button until snoop mode is on, then release it
    task automatic enable_snoop();
        for (int k = 0; k < 8 && !board.snoop_on; k++)
            send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b1, 1'b1, 1'b1);
    endtask

    // One bus frame: START, match bits, overridden bits, STOP; maybe spoilt
    task automatic run_frame();
        bit   bad_match;
        bit   bad_readback;
        int   bad_bit;
        int   bad_slot;
        logic b;
        bad_match    = ($urandom_range(99) < 20);
        bad_readback = ($urandom_range(99) < 20);
        bad_bit      = $urandom_range(MATCH_BITS_DEF - 1);
        bad_slot     = $urandom_range(OVERRIDE_BITS_DEF - 1);
        enable_snoop();
        hold_pins(1'b1, 1'b1);
        hold_pins(1'b1, 1'b0);
        for (int i = 0; i < MATCH_BITS_DEF; i++)
        begin
            b = board.match_pat[MATCH_BITS_DEF-1-i] ^ (bad_match && i == bad_bit);
            hold_pins(1'b0, b);
            hold_pins(1'b1, b);
            if (bad_match && i == bad_bit)
                return;
        end
        for (int j = 0; j < OVERRIDE_BITS_DEF; j++)
        begin
            b = board.ovr_pat[OVERRIDE_BITS_DEF-1-j];
            hold_pins(1'b0, b);
            hold_pins(1'b1, b ^ (bad_readback && j == bad_slot));
        end
        hold_pins(1'b0, 1'b0);
        hold_pins(1'b1, 1'b0);
        hold_pins(1'b1, 1'b1);
    endtask

    // Mostly frames, the rest pin noise, button presses and idle bus
    task automatic run_traffic(input int n, input bit pause_mid, input bit hold_mid);
        int stop_at;
        int pick;
        stop_at = sent_cnt + n;
        while (sent_cnt < stop_at)
        begin
            if ((pause_mid || hold_mid) && sent_cnt >= stop_at - n / 2)
            begin
                if (pause_mid)
                    wait_drained();
                if (hold_mid)
                    stall_req = 1'b1;
                pause_mid = 1'b0;
                hold_mid  = 1'b0;
            end
            pick = $urandom_range(99);
            if (pick < 60)
                run_frame();
            else if (pick < 78)
                repeat ($urandom_range(1, 10))
                    send_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                                1'($urandom_range(1)));
            else if (pick < 90)
            begin
                repeat ($urandom_range(1, 8))
                    send_sample(1'b1, 1'b1, 1'b0);
                send_sample(1'b1, 1'b1, 1'b1);
            end
            else
                repeat ($urandom_range(1, 4))
                    send_sample(1'b1, 1'b1, 1'b1);
        end
    endtask

    initial
    begin
        logic [2:0] p;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles lightly, receiver heavily; patterns start at their reset values
        send_idle_pct = 27;
        recv_idle_pct = 82;
        write_reg(REG_LOCKOUT, CFG_W'(2), 1'b1);
        for (int k = 0; k < DIRECTED_LEN; k++)
        begin
            p = DIRECTED_PINS[3*(DIRECTED_LEN-1-k) +: 3];
            send_sample(p[2], p[1], p[0]);
        end
        run_traffic(PHASE_ITEMS, 1'b0, 1'b0);
        wait_drained();

        write_reg(REG_MATCH, '0, 1'b0);
        write_reg(REG_OVERRIDE, '0, 1'b0);
        write_reg(REG_LOCKOUT, '0, 1'b1);
        run_traffic(PHASE_ITEMS, 1'b0, 1'b0);
        wait_drained();

        // Sender idles heavily, receiver lightly
        send_idle_pct = 82;
        recv_idle_pct = 27;
        write_reg(REG_MATCH, '1, 1'b0);
        write_reg(REG_OVERRIDE, '1, 1'b0);
        write_reg(REG_LOCKOUT, CFG_W'(1), 1'b1);
        run_traffic(PHASE_ITEMS, 1'b1, 1'b0);
        wait_drained();

        write_reg(REG_MATCH, CFG_W'($urandom), 1'b0);
        write_reg(REG_OVERRIDE, CFG_W'($urandom), 1'b0);
        write_reg(REG_LOCKOUT, CFG_W'($urandom_range(0, 6)), 1'b1);
        run_traffic(PHASE_ITEMS, 1'b0, 1'b0);
        wait_drained();

        // No idling on either side; long receiver hold-off halfway through
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_MATCH, CFG_W'($urandom), 1'b0);
        write_reg(REG_OVERRIDE, CFG_W'($urandom), 1'b0);
        write_reg(REG_LOCKOUT, CFG_W'($urandom_range(3, 10)), 1'b1);
        run_traffic(PHASE_ITEMS, 1'b0, 1'b1);
        wait_drained();

        write_reg(REG_MATCH, CFG_W'($urandom), 1'b0);
        write_reg(REG_OVERRIDE, CFG_W'($urandom), 1'b0);
        write_reg(REG_UNUSED, CFG_W'($urandom), 1'b0);
        write_reg(REG_LOCKOUT, '1, 1'b1);
        run_traffic(PHASE_ITEMS, 1'b0, 1'b0);
        wait_drained();

        repeat (10) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== i2c_snoop_bit_patcher.f =====
+incdir+rtl/core
rtl/core/i2csbp_pkg.sv
rtl/core/i2csbp_core.sv
rtl/core/i2c_snoop_bit_patcher.sv
tb/tb_i2c_snoop_bit_patcher.sv
